FILE: sv/isa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and constants of the input selector with automatic search:
// phase codes, tick and result payloads, register indexes and defaults.
// ----------------------------------------------------------------------------
package isa_pkg;

    // Phase of the selector sequencer
    typedef enum logic [2:0] {
        PH_POWER  = 3'd0,
        PH_IDLE   = 3'd1,
        PH_SETTLE = 3'd2,
        PH_COUNT  = 3'd3,
        PH_PRESS  = 3'd4
    } t_phase;

    // One millisecond tick
    typedef struct packed {
        logic       button_level;
        logic       button_edge;
        logic       lock;
        logic [3:0] edge_count;
    } t_in_item;

    // One result per tick
    typedef struct packed {
        logic [4:0] relay_drive;
        logic       dac_enable;
        logic       searching;
        logic [2:0] selected_input;
    } t_out_item;

    // Configuration register set
    typedef struct packed {
        logic [2:0]  start_input;
        logic [15:0] long_press_units;
        logic [15:0] settle_ticks;
        logic [15:0] count_window_ticks;
        logic [3:0]  edge_threshold;
        logic [15:0] power_on_ticks;
    } t_cfg_regs;

    // Register indexes
    localparam logic [2:0] CFG_START_INPUT  = 3'd0;
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] CFG_SETTLE       = 3'd2;
    localparam logic [2:0] CFG_COUNT_WINDOW = 3'd3;
    localparam logic [2:0] CFG_EDGE_THRESH  = 3'd4;
    localparam logic [2:0] CFG_POWER_ON     = 3'd5;

    // Register reset values
    localparam logic [2:0]  RST_START_INPUT  = 3'd0;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd100;
    localparam logic [15:0] RST_SETTLE       = 16'd100;
    localparam logic [15:0] RST_COUNT_WINDOW = 16'd10;
    localparam logic [3:0]  RST_EDGE_THRESH  = 4'd10;
    localparam logic [15:0] RST_POWER_ON     = 16'd1000;

    // Ticks per press sampling unit
    localparam logic [15:0] PRESS_UNIT_TICKS = 16'd5;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [3:0]  PULSE_MAX        = 4'd15;
    localparam logic [4:0]  RELAY_ALL_OFF    = 5'h1F;

endpackage

FILE: sv/isa_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_core
// Configuration registers, selector state and the one-tick update. The next
// result is formed combinationally from the tick and the current state.
// ----------------------------------------------------------------------------
module isa_core
    import isa_pkg::*;
#(
    parameter int INPUT_COUNT = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_out_item o_result
);

    localparam logic [2:0] LAST_INPUT = 3'(INPUT_COUNT - 1);

    t_cfg_regs   r_cfg;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_cur, n_cur;
    logic [2:0]  r_app, n_app;
    logic [15:0] r_wait, n_wait;
    logic [15:0] r_press, n_press;
    logic [3:0]  r_pulse, n_pulse;
    logic        r_cnt_on, n_cnt_on;
    logic        r_search, n_search;
    logic        r_dac, n_dac;

    logic [4:0]  w_sum;
    logic [15:0] w_wait_inc;
    logic [2:0]  w_cur_step;
    logic [7:0]  w_onehot;

    assign w_sum      = {1'b0, r_pulse} + {1'b0, i_item.edge_count};
    assign w_wait_inc = (r_wait == COUNT_MAX) ? r_wait : r_wait + 16'd1;
    assign w_cur_step = (r_cur >= LAST_INPUT) ? 3'd0 : r_cur + 3'd1;

    // Next state for one tick
    always_comb begin
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_app    = r_app;
        n_wait   = r_wait;
        n_press  = r_press;
        n_pulse  = r_pulse;
        n_cnt_on = r_cnt_on;
        n_search = r_search;
        n_dac    = r_dac;

        // accumulate data edges, stop once above threshold
        if (r_cnt_on) begin
            n_pulse = (w_sum > {1'b0, PULSE_MAX}) ? PULSE_MAX : w_sum[3:0];
            if (n_pulse > r_cfg.edge_threshold) begin
                n_cnt_on = 1'b0;
            end
        end

        case (r_phase)
            PH_POWER: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= r_cfg.power_on_ticks) begin
                    n_dac   = 1'b1;
                    n_wait  = '0;
                    n_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (i_item.button_level) begin
                    n_dac   = 1'b0;
                    n_press = '0;
                    n_wait  = '0;
                    n_phase = PH_PRESS;
                end
            end
            PH_SETTLE: begin
                if (i_item.button_edge) begin
                    n_cur  = w_cur_step;
                    n_wait = '0;
                    if (i_item.button_level) begin
                        n_dac   = 1'b0;
                        n_press = '0;
                        n_phase = PH_PRESS;
                    end else begin
                        n_cnt_on = 1'b0;
                        n_phase  = PH_SETTLE;
                    end
                end else begin
                    n_wait = w_wait_inc;
                    if (w_wait_inc >= r_cfg.settle_ticks) begin
                        n_wait = '0;
                        if (i_item.lock) begin
                            n_pulse  = '0;
                            n_cnt_on = 1'b1;
                            n_phase  = PH_COUNT;
                        end else begin
                            n_cur    = w_cur_step;
                            n_cnt_on = 1'b0;
                        end
                    end
                end
            end
            PH_COUNT: begin
                if (i_item.button_edge || (w_wait_inc >= r_cfg.count_window_ticks)) begin
                    // judge the counted input
                    n_cnt_on = 1'b0;
                    if (n_pulse > r_cfg.edge_threshold) begin
                        n_search = 1'b0;
                        n_dac    = 1'b1;
                        n_phase  = PH_IDLE;
                        n_wait   = i_item.button_edge ? r_wait : w_wait_inc;
                    end else begin
                        n_cur   = w_cur_step;
                        n_wait  = '0;
                        n_phase = PH_SETTLE;
                    end
                    if (i_item.button_edge && i_item.button_level) begin
                        n_dac   = 1'b0;
                        n_press = '0;
                        n_wait  = '0;
                        n_phase = PH_PRESS;
                    end
                end else begin
                    n_wait = w_wait_inc;
                end
            end
            PH_PRESS: begin
                n_wait = w_wait_inc;
                if (w_wait_inc >= PRESS_UNIT_TICKS) begin
                    n_wait  = '0;
                    n_press = (r_press == COUNT_MAX) ? r_press : r_press + 16'd1;
                    if (!i_item.button_level) begin
                        n_cur = w_cur_step;
                        if (n_press < r_cfg.long_press_units) begin
                            n_search = 1'b0;
                            n_cnt_on = 1'b0;
                            n_dac    = 1'b1;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_search = 1'b1;
                            n_cnt_on = 1'b0;
                            n_phase  = PH_SETTLE;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // drive the relays to the new selection outside power-on and press
        if (n_phase != PH_POWER && n_phase != PH_PRESS && r_app != n_cur) begin
            n_app   = n_cur;
            n_pulse = '0;
        end
    end

    // Result of this tick
    always_comb begin
        w_onehot                = 8'd1 << n_app;
        o_result.relay_drive    = RELAY_ALL_OFF ^ w_onehot[4:0];
        o_result.dac_enable     = n_dac;
        o_result.searching      = n_search;
        o_result.selected_input = n_cur;
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_input        <= RST_START_INPUT;
            r_cfg.long_press_units   <= RST_LONG_PRESS;
            r_cfg.settle_ticks       <= RST_SETTLE;
            r_cfg.count_window_ticks <= RST_COUNT_WINDOW;
            r_cfg.edge_threshold     <= RST_EDGE_THRESH;
            r_cfg.power_on_ticks     <= RST_POWER_ON;
            r_phase  <= PH_POWER;
            r_cur    <= RST_START_INPUT;
            r_app    <= RST_START_INPUT;
            r_wait   <= '0;
            r_press  <= '0;
            r_pulse  <= '0;
            r_cnt_on <= 1'b0;
            r_search <= 1'b0;
            r_dac    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_INPUT: begin
                    r_cfg.start_input <= i_cfg_data[2:0];
                    if (r_phase == PH_POWER) begin
                        r_cur <= i_cfg_data[2:0];
                        r_app <= i_cfg_data[2:0];
                    end
                end
                CFG_LONG_PRESS:   r_cfg.long_press_units   <= i_cfg_data;
                CFG_SETTLE:       r_cfg.settle_ticks       <= i_cfg_data;
                CFG_COUNT_WINDOW: r_cfg.count_window_ticks <= i_cfg_data;
                CFG_EDGE_THRESH:  r_cfg.edge_threshold     <= i_cfg_data[3:0];
                CFG_POWER_ON:     r_cfg.power_on_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cur    <= n_cur;
            r_app    <= n_app;
            r_wait   <= n_wait;
            r_press  <= n_press;
            r_pulse  <= n_pulse;
            r_cnt_on <= n_cnt_on;
            r_search <= n_search;
            r_dac    <= n_dac;
        end
    end

endmodule

FILE: sv/isa_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_out_reg
// Result register of the output channel. Takes a new result whenever it is
// empty or its current result transfers in the same cycle.
// ----------------------------------------------------------------------------
module isa_out_reg
    import isa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_data,
    output logic      o_can_load,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    // Hold the result until it transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: sv/input_selector_autosearch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_selector_autosearch
// Input selector with automatic signal search, stepped by millisecond ticks.
//
// Each tick transfers on the input channel (i_in_valid / o_in_ready) with the
// button level, press edge, receiver lock and data edge count. Every tick
// yields one result on the output channel (o_out_valid / i_out_ready): the
// active-low one-hot relay drive, DAC enable, search flag and selection.
// The result is registered: it appears in the result register on the
// clock after the tick transfers. Throughput is one tick per cycle while
// results are taken; the update is a single pass of counters and compares
// between the state registers and the result register.
// A stalled receiver holds the result; a new tick is still taken in the
// cycle where the held result transfers. Ticks stop only while a result
// waits and is not taken.
// Reset restores the register defaults and enters the power-on wait with the
// start input selected. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) take effect at once; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module input_selector_autosearch
    import isa_pkg::*;
#(
    parameter int INPUT_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic      w_accept;
    logic      w_can_load;
    t_out_item w_result;

    assign o_in_ready = w_can_load;
    assign w_accept   = i_in_valid && w_can_load;

    // Tick update and configuration
    isa_core #(
        .INPUT_COUNT(INPUT_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_accept),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (w_result)
    );

    // Result register
    isa_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_data     (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_item)
    );

endmodule

FILE: tb/input_selector_autosearch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_selector_autosearch_checker
// Passive checker for the input selector. It follows the configuration port,
// steps its own model of the selector on every tick transfer, queues the
// predicted output, and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module input_selector_autosearch_checker
    import isa_pkg::*;
#(
    parameter int INPUT_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int SHOWN_MAX = 100;

    // Register copy and selector state
    t_cfg_regs   regs;
    t_phase      sel_phase;
    logic [2:0]  cur_sel;
    logic [2:0]  applied_sel;
    logic [15:0] wait_cnt;
    logic [15:0] press_cnt;
    logic [3:0]  pulse_sum;
    logic        edge_counting;
    logic        hunting;
    logic        dac_path;

    t_out_item   selector_outputs_q[$];
    int          queued   = 0;
    int          fail_cnt = 0;

    assign o_pending    = queued;
    assign o_fail_count = fail_cnt;

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(input string msg);
        if (fail_cnt < SHOWN_MAX)
            $display("%0t: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    // Advance the wait timer, saturating
    function automatic void tick_wait();
        if (wait_cnt != COUNT_MAX)
            wait_cnt++;
    endfunction

    // Move to the next input; out-of-range selections wrap to the first
    function automatic void advance_input();
        if (int'(cur_sel) >= INPUT_COUNT - 1)
            cur_sel = 3'd0;
        else
            cur_sel = cur_sel + 3'd1;
    endfunction

    function automatic void enter_press();
        dac_path  = 1'b0;
        press_cnt = '0;
        wait_cnt  = '0;
        sel_phase = PH_PRESS;
    endfunction

    function automatic void enter_settle();
        wait_cnt      = '0;
        edge_counting = 1'b0;
        sel_phase     = PH_SETTLE;
    endfunction

    // Accept the input when enough data edges were seen, else search on
    function automatic void close_window();
        edge_counting = 1'b0;
        if (pulse_sum > regs.edge_threshold) begin
            hunting   = 1'b0;
            dac_path  = 1'b1;
            sel_phase = PH_IDLE;
        end else begin
            advance_input();
            enter_settle();
        end
    endfunction

    // Step the selector by one millisecond tick and form its output
    function automatic t_out_item step_selector(input t_in_item tick);
        logic [4:0] sum;
        logic [7:0] onehot;
        t_out_item  res;

        // Accumulate data edges while the window is open
        if (edge_counting) begin
            sum = {1'b0, pulse_sum} + {1'b0, tick.edge_count};
            pulse_sum = (sum > 5'd15) ? PULSE_MAX : sum[3:0];
            if (pulse_sum > regs.edge_threshold)
                edge_counting = 1'b0;
        end

        case (sel_phase)
            PH_POWER: begin
                tick_wait();
                if (wait_cnt >= regs.power_on_ticks) begin
                    dac_path  = 1'b1;
                    wait_cnt  = '0;
                    sel_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (tick.button_level)
                    enter_press();
            end
            PH_SETTLE: begin
                if (tick.button_edge) begin
                    advance_input();
                    if (tick.button_level)
                        enter_press();
                    else
                        enter_settle();
                end else begin
                    tick_wait();
                    if (wait_cnt >= regs.settle_ticks) begin
                        if (tick.lock) begin
                            pulse_sum     = '0;
                            edge_counting = 1'b1;
                            wait_cnt      = '0;
                            sel_phase     = PH_COUNT;
                        end else begin
                            advance_input();
                            enter_settle();
                        end
                    end
                end
            end
            PH_COUNT: begin
                if (tick.button_edge) begin
                    close_window();
                    if (tick.button_level)
                        enter_press();
                end else begin
                    tick_wait();
                    if (wait_cnt >= regs.count_window_ticks)
                        close_window();
                end
            end
            PH_PRESS: begin
                tick_wait();
                if (wait_cnt >= PRESS_UNIT_TICKS) begin
                    wait_cnt = '0;
                    if (press_cnt != COUNT_MAX)
                        press_cnt++;
                    if (!tick.button_level) begin
                        advance_input();
                        if (press_cnt < regs.long_press_units) begin
                            hunting       = 1'b0;
                            edge_counting = 1'b0;
                            dac_path      = 1'b1;
                            sel_phase     = PH_IDLE;
                        end else begin
                            hunting = 1'b1;
                            enter_settle();
                        end
                    end
                end
            end
            default: begin
                sel_phase = PH_IDLE;
            end
        endcase

        // Switch the relays once the selection is stable
        if (sel_phase != PH_POWER && sel_phase != PH_PRESS && applied_sel != cur_sel) begin
            applied_sel = cur_sel;
            pulse_sum   = '0;
        end

        onehot             = 8'd1 << applied_sel;
        res.relay_drive    = RELAY_ALL_OFF ^ onehot[4:0];
        res.dac_enable     = dac_path;
        res.searching      = hunting;
        res.selected_input = cur_sel;
        return res;
    endfunction

    // Follow reset, register writes and both channels
    always @(posedge i_clk) begin
        t_out_item want;

        if (!i_rst_n) begin
            regs.start_input        = RST_START_INPUT;
            regs.long_press_units   = RST_LONG_PRESS;
            regs.settle_ticks       = RST_SETTLE;
            regs.count_window_ticks = RST_COUNT_WINDOW;
            regs.edge_threshold     = RST_EDGE_THRESH;
            regs.power_on_ticks     = RST_POWER_ON;
            sel_phase     = PH_POWER;
            cur_sel       = RST_START_INPUT;
            applied_sel   = RST_START_INPUT;
            wait_cnt      = '0;
            press_cnt     = '0;
            pulse_sum     = '0;
            edge_counting = 1'b0;
            hunting       = 1'b0;
            dac_path      = 1'b0;
            selector_outputs_q.delete();
        end else begin
            // Apply a register write; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_INPUT: begin
                        regs.start_input = i_cfg_data[2:0];
                        if (sel_phase == PH_POWER) begin
                            cur_sel     = i_cfg_data[2:0];
                            applied_sel = i_cfg_data[2:0];
                        end
                    end
                    CFG_LONG_PRESS:   regs.long_press_units   = i_cfg_data;
                    CFG_SETTLE:       regs.settle_ticks       = i_cfg_data;
                    CFG_COUNT_WINDOW: regs.count_window_ticks = i_cfg_data;
                    CFG_EDGE_THRESH:  regs.edge_threshold     = i_cfg_data[3:0];
                    CFG_POWER_ON:     regs.power_on_ticks     = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare a result transfer with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (selector_outputs_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no tick outstanding",
                                              i_out_item));
                end else begin
                    want = selector_outputs_q.pop_front();
                    if (i_out_item.relay_drive !== want.relay_drive)
                        report_mismatch($sformatf("relay_drive expected %0d got %0d",
                                                  want.relay_drive, i_out_item.relay_drive));
                    if (i_out_item.dac_enable !== want.dac_enable)
                        report_mismatch($sformatf("dac_enable expected %0d got %0d",
                                                  want.dac_enable, i_out_item.dac_enable));
                    if (i_out_item.searching !== want.searching)
                        report_mismatch($sformatf("searching expected %0d got %0d",
                                                  want.searching, i_out_item.searching));
                    if (i_out_item.selected_input !== want.selected_input)
                        report_mismatch($sformatf("selected_input expected %0d got %0d",
                                                  want.selected_input,
                                                  i_out_item.selected_input));
                end
            end

            // Predict the output of an accepted tick
            if (i_in_valid && i_in_ready)
                selector_outputs_q.push_back(step_selector(i_in_item));
        end
        queued = selector_outputs_q.size();
    end

endmodule

FILE: tb/input_selector_autosearch_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_selector_autosearch_test
// Stimulus and verdict for the input selector. A directed opening covers the
// power-on wait, an out-of-range start input, short and long presses and an
// accepted search; random phases then replay presses, automatic searches and
// noise under changing register settings and handshake pressure.
// ----------------------------------------------------------------------------
module input_selector_autosearch_test;
    import isa_pkg::*;

    localparam int         N_INPUTS      = 5;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PHASE_COUNT   = 9;
    localparam int         PHASE_TICKS   = 95;
    localparam logic [2:0] CFG_SPARE_IDX = 3'd6;

    // Register settings per random phase; the last one is drawn at random
    int long_tab   [PHASE_COUNT] = '{3, 0, 1, 65535, 2, 2, 4, 1, 3};
    int settle_tab [PHASE_COUNT] = '{2, 0, 4, 1, 65535, 1, 3, 0, 2};
    int window_tab [PHASE_COUNT] = '{3, 0, 6, 2, 1, 65535, 5, 2, 4};
    int thresh_tab [PHASE_COUNT] = '{5, 0, 14, 10, 3, 15, 8, 2, 6};
    int start_tab  [PHASE_COUNT] = '{2, 4, 5, 7, 1, 3, 0, 6, 2};
    int power_tab  [PHASE_COUNT] = '{0, 65535, 7, 1, 3, 0, 9, 2, 5};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_item;
    int          pending;
    int          fail_count;

    int snd_idle_pct = 34;
    int rcv_idle_pct = 87;
    int ticks_sent   = 0;
    int long_units   = 2;
    int cycle_cnt    = 0;

    input_selector_autosearch #(
        .INPUT_COUNT (N_INPUTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    input_selector_autosearch_checker #(
        .INPUT_COUNT (N_INPUTS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("input_selector_autosearch test failed");
            $finish;
        end
    end

    // Offer one tick after a random gap and hold it until the transfer
    task automatic send_tick(input logic level, input logic press, input logic locked,
                             input logic [3:0] edges);
        t_in_item tick;

        tick.button_level = level;
        tick.button_edge  = press;
        tick.lock         = locked;
        tick.edge_count   = edges;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= tick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic send_burst(input logic level, input logic press, input logic locked,
                              input logic [3:0] edges, input int n);
        repeat (n)
            send_tick(level, press, locked, edges);
    endtask

    function automatic logic rand_lock();
        return ($urandom_range(9) < 8);
    endfunction

    // Mostly sparse edges, sometimes the full range
    function automatic logic [3:0] rand_edges();
        return ($urandom_range(1) == 1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    endfunction

    // Hold the button for a number of ticks, then release it
    task automatic press_button(input int hold);
        for (int k = 0; k < hold; k++)
            send_tick(1'b1, (k == 0), rand_lock(), rand_edges());
        repeat ($urandom_range(5, 9))
            send_tick(1'b0, ($urandom_range(9) == 0), rand_lock(), rand_edges());
    endtask

    // Drive one register index; the caller lowers the write enable
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write the full register set plus one unused index
    task automatic load_settings(input logic [2:0] start, input logic [15:0] lp,
                                 input logic [15:0] settle, input logic [15:0] window,
                                 input logic [3:0] thr, input logic [15:0] power);
        write_reg(CFG_START_INPUT, {13'd0, start});
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_COUNT_WINDOW, window);
        write_reg(CFG_EDGE_THRESH, {12'd0, thr});
        write_reg(CFG_POWER_ON, power);
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        cfg_we <= 1'b0;
        long_units = int'(lp);
    endtask

    // Stop offering ticks and wait for every result to transfer
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin
        int phase_start;
        int pick;
        int hold;
        int last;

        last = PHASE_COUNT - 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on wait ignores the button; reload the start input while waiting
        load_settings(3'd6, 16'd2, 16'd1, 16'd2, 4'd0, 16'd4);
        send_burst(1'b1, 1'b1, 1'b1, 4'd15, 2);
        drain();
        write_reg(CFG_START_INPUT, 16'd7);
        cfg_we <= 1'b0;
        send_burst(1'b0, 1'b0, 1'b0, 4'd0, 2);
        // Edge without level, then a short press that wraps the out-of-range input
        send_tick(1'b0, 1'b1, 1'b0, 4'd0);
        send_tick(1'b1, 1'b1, 1'b0, 4'd0);
        send_burst(1'b0, 1'b0, 1'b0, 4'd0, 5);
        // Long press, then settle, lock, count and accept
        send_tick(1'b1, 1'b1, 1'b1, 4'd15);
        send_burst(1'b1, 1'b0, 1'b1, 4'd15, 5);
        send_burst(1'b0, 1'b0, 1'b0, 4'd0, 5);
        send_burst(1'b0, 1'b0, 1'b1, 4'd15, 2);
        send_tick(1'b0, 1'b0, 1'b0, 4'd0);
        drain();

        // Random phases: three idling patterns, each over three settings
        for (int p = 0; p < PHASE_COUNT; p++) begin
            snd_idle_pct = (p < 3) ? 34 : (p < 6) ? 87 : 0;
            rcv_idle_pct = (p < 3) ? 87 : (p < 6) ? 34 : 0;
            load_settings((p == last) ? 3'($urandom_range(7))      : 3'(start_tab[p]),
                          (p == last) ? 16'($urandom_range(5))     : 16'(long_tab[p]),
                          (p == last) ? 16'($urandom_range(6))     : 16'(settle_tab[p]),
                          (p == last) ? 16'($urandom_range(8))     : 16'(window_tab[p]),
                          (p == last) ? 4'($urandom_range(15))     : 4'(thresh_tab[p]),
                          (p == last) ? 16'($urandom)              : 16'(power_tab[p]));
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // Long press followed by a watched search
                    hold = (long_units > 11) ? 60 : 5 * long_units + $urandom_range(1, 5);
                    press_button(hold);
                    for (int k = $urandom_range(8, 40); k > 0; k--) begin
                        if ($urandom_range(24) == 0)
                            send_tick($urandom_range(2) == 0, 1'b1, rand_lock(),
                                      rand_edges());
                        else
                            send_tick(1'b0, 1'b0, rand_lock(), rand_edges());
                    end
                end else if (pick < 75) begin
                    press_button($urandom_range(1, 12));
                end else begin
                    repeat ($urandom_range(3, 10))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 4'($urandom_range(15)));
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("input_selector_autosearch test passed");
        else
            $display("input_selector_autosearch test failed");
        $finish;
    end

endmodule

FILE: files.f
sv/isa_pkg.sv
sv/isa_core.sv
sv/isa_out_reg.sv
sv/input_selector_autosearch.sv
tb/input_selector_autosearch_checker.sv
tb/input_selector_autosearch_test.sv
